>>> hdl/safs_pkg.sv
// safs_pkg: shared constants, item layouts and controller/datapath types
// for the sprite animation frame sequencer
// no dependencies
`default_nettype none

package safs_pkg;

    // default configuration of the sequencer
    localparam int ANIM_COUNT_DEF = 8;
    localparam int FRAME_BITS_DEF = 8;
    localparam int TIME_BITS_DEF  = 16;

    // configuration port
    localparam int TABLE_REGS = 8;
    localparam int CFG_IDX_W  = 4;
    localparam int ENTRY_W    = 33;

    // packed animation entry layout
    localparam int ENT_TIME_W    = 16;
    localparam int ENT_CNT_LSB   = 16;
    localparam int ENT_CNT_W     = 8;
    localparam int ENT_START_LSB = 24;
    localparam int ENT_START_W   = 8;
    localparam int ENT_ONCE_BIT  = 32;

    // time accumulator
    localparam int ACCUM_W = 32;

    // input item
    localparam int KIND_W      = 2;
    localparam int ELAPSED_W   = 16;
    localparam int ID_W        = 3;
    localparam int IN_ID_LSB   = ELAPSED_W;
    localparam int IN_USED_W   = ELAPSED_W + ID_W;
    localparam int IN_DATA_W   = ((IN_USED_W + 7) / 8) * 8;

    // result item
    localparam int FRAME_OUT_W   = 8;
    localparam int SHEET_W       = 9;
    localparam int OUT_TICK_LSB  = 0;
    localparam int OUT_BASE_LSB  = 1;
    localparam int OUT_OS_LSB    = 2;
    localparam int OUT_SHOWN_LSB = 3;
    localparam int OUT_FRAME_LSB = OUT_SHOWN_LSB + ID_W;
    localparam int OUT_SHEET_LSB = OUT_FRAME_LSB + FRAME_OUT_W;
    localparam int OUT_USED_W    = OUT_SHEET_LSB + SHEET_W;
    localparam int OUT_DATA_W    = ((OUT_USED_W + 7) / 8) * 8;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK    = 2'd0,
        KIND_SELECT  = 2'd1,
        KIND_ONESHOT = 2'd2
    } safs_kind_t;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture the input item
        logic apply;     // select, one-shot start or time accumulate
        logic div_start; // launch the shared divider
        logic div_mod;   // divider operands: wrap (n - s) / count
        logic cmp;       // register n >= steps to end
        logic mul;       // register the time to take off
        logic update;    // write back time and frame
        logic take_mod;  // frame from the divider remainder
        logic emit;      // load the result register
    } safs_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic tick_run;  // tick with a base selected
        logic gt;        // accumulated time beyond one frame time
        logic div_busy;
        logic need_mod;  // looping base ran past its end
    } safs_sts_t;

endpackage

`default_nettype wire

>>> hdl/safs_div.sv
// safs_div: iterative unsigned divider, two quotient bits per cycle
// standalone, no package dependency
`default_nettype none

module safs_div #(
    parameter int DVD_W = 32,
    parameter int DVS_W = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [DVD_W-1:0] dividend,
    input  wire logic [DVS_W-1:0] divisor,
    output logic                  busy,
    output logic [DVD_W-1:0]      quotient,
    output logic [DVS_W-1:0]      remainder
);

    localparam int STEPS = DVD_W / 2;
    localparam int CW    = $clog2(STEPS);

    logic             busy_reg;
    logic [CW-1:0]    cnt_reg;
    logic [DVD_W-1:0] quo_reg;
    logic [DVD_W-1:0] quo_next;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] rem_next;
    logic [DVS_W-1:0] dvs_reg;

    // two restoring steps: dividend bits leave the top of quo, quotient bits enter below
    always_comb
    begin
        logic [DVS_W:0] trial;
        rem_next = rem_reg;
        quo_next = quo_reg;
        for (int k = 0; k < 2; k++)
        begin
            trial    = {rem_next, quo_next[DVD_W-1]};
            quo_next = {quo_next[DVD_W-2:0], 1'b0};
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next    = DVS_W'(trial - {1'b0, dvs_reg});
                quo_next[0] = 1'b1;
            end
            else
            begin
                rem_next = trial[DVS_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + CW'(1);
            if (cnt_reg == CW'(STEPS - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

>>> hdl/safs_dp.sv
// safs_dp: animation table, sequencer state, divider, multiplier and result register
// depends on safs_pkg and safs_div
`default_nettype none

module safs_dp #(
    parameter int ANIM_COUNT = safs_pkg::ANIM_COUNT_DEF,
    parameter int FRAME_BITS = safs_pkg::FRAME_BITS_DEF,
    parameter int TIME_BITS  = safs_pkg::TIME_BITS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_wen,
    input  wire logic [safs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [safs_pkg::ENTRY_W-1:0]     cfg_data,
    input  wire logic [safs_pkg::KIND_W-1:0]      in_kind,
    input  wire logic [safs_pkg::ELAPSED_W-1:0]   in_elapsed,
    input  wire logic [safs_pkg::ID_W-1:0]        in_id,
    input  wire safs_pkg::safs_cmd_t              cmd,
    output safs_pkg::safs_sts_t                   sts,
    output logic [safs_pkg::OUT_DATA_W-1:0]       out_data
);

    import safs_pkg::*;

    localparam int AW       = (ANIM_COUNT > 1) ? $clog2(ANIM_COUNT) : 1;
    localparam int FT_W     = (TIME_BITS < ENT_TIME_W) ? TIME_BITS : ENT_TIME_W;
    localparam int CN_W     = (FRAME_BITS < ENT_CNT_W) ? FRAME_BITS : ENT_CNT_W;
    localparam int DVS_W    = (FT_W > CN_W) ? FT_W : CN_W;
    localparam int WR_LIMIT = (ANIM_COUNT < TABLE_REGS) ? ANIM_COUNT : TABLE_REGS;

    // table and sequencer state
    logic [ENTRY_W-1:0]    anim_tab_reg [ANIM_COUNT];
    logic [AW-1:0]         base_id_reg;
    logic                  base_ok_reg;
    logic [AW-1:0]         os_id_reg;
    logic                  os_ok_reg;
    logic [FRAME_BITS-1:0] frame_reg;
    logic [ACCUM_W-1:0]    accum_reg;

    // item and working registers
    safs_kind_t            kind_reg;
    logic [ELAPSED_W-1:0]  elapsed_reg;
    logic [ID_W-1:0]       id_reg;
    logic                  nge_reg;
    logic [ACCUM_W-1:0]    prod_reg;
    logic [OUT_DATA_W-1:0] out_reg;
    logic [OUT_DATA_W-1:0] out_next;

    logic [AW-1:0]         cur_id;
    logic [ENTRY_W-1:0]    ent;
    logic [FT_W-1:0]       ft;
    logic [CN_W-1:0]       cnt;
    logic [ENT_START_W-1:0] start_idx;
    logic                  once;
    logic [FRAME_BITS-1:0] steps_left;
    logic [AW-1:0]         id_aw;
    logic                  id_ok;
    logic [ACCUM_W:0]      acc_sum;
    logic [ACCUM_W-1:0]    acc_sat;
    logic [ACCUM_W-1:0]    mul_a;

    logic                  div_start;
    logic [ACCUM_W-1:0]    div_dvd;
    logic [DVS_W-1:0]      div_dvs;
    logic                  div_busy;
    logic [ACCUM_W-1:0]    div_quo;
    logic [DVS_W-1:0]      div_rem;

    logic                  has_any;
    logic [ID_W-1:0]       shown;
    logic [FRAME_OUT_W-1:0] frame8;
    logic [SHEET_W-1:0]    sheet;
    logic                  tick_ok;

    // entry of the animation on show; zero time or count counts as one
    always_comb
    begin
        cur_id     = os_ok_reg ? os_id_reg : base_id_reg;
        ent        = anim_tab_reg[cur_id];
        ft         = (ent[FT_W-1:0] == '0) ? FT_W'(1) : ent[FT_W-1:0];
        cnt        = (ent[ENT_CNT_LSB +: CN_W] == '0) ? CN_W'(1) : ent[ENT_CNT_LSB +: CN_W];
        start_idx  = ent[ENT_START_LSB +: ENT_START_W];
        once       = ent[ENT_ONCE_BIT];
        // frames to the end of the run, one when already at or beyond it
        steps_left = (frame_reg < FRAME_BITS'(cnt)) ? FRAME_BITS'(cnt) - frame_reg
                                                     : FRAME_BITS'(1);
        id_aw      = AW'(id_reg);
        id_ok      = 32'(id_reg) < 32'(ANIM_COUNT);
        acc_sum    = {1'b0, accum_reg} + (ACCUM_W + 1)'(elapsed_reg);
        acc_sat    = acc_sum[ACCUM_W] ? '1 : acc_sum[ACCUM_W-1:0];
        mul_a      = (os_ok_reg && nge_reg) ? ACCUM_W'(steps_left) : div_quo;
    end

    // divider operands: frames passed, or the wrap position of a looping base
    assign div_start = cmd.div_start;
    assign div_dvd   = cmd.div_mod ? div_quo - ACCUM_W'(steps_left) : accum_reg - ACCUM_W'(1);
    assign div_dvs   = cmd.div_mod ? DVS_W'(cnt) : DVS_W'(ft);

    safs_div #(
        .DVD_W (ACCUM_W),
        .DVS_W (DVS_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dvd),
        .divisor   (div_dvs),
        .busy      (div_busy),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ANIM_COUNT; i++)
            begin
                anim_tab_reg[i] <= '0;
            end
            base_id_reg <= '0;
            base_ok_reg <= 1'b0;
            os_id_reg   <= '0;
            os_ok_reg   <= 1'b0;
            frame_reg   <= '0;
            accum_reg   <= '0;
        end
        else
        begin
            if (cfg_wen && (32'(cfg_index) < 32'(WR_LIMIT)))
            begin
                anim_tab_reg[AW'(cfg_index)] <= cfg_data;
            end

            if (cmd.apply)
            begin
                case (kind_reg)
                    KIND_TICK:
                    begin
                        if (base_ok_reg)
                        begin
                            accum_reg <= acc_sat;
                        end
                    end
                    KIND_SELECT:
                    begin
                        // reselecting the current base keeps frame and time
                        if (id_ok && (!base_ok_reg || base_id_reg != id_aw))
                        begin
                            base_id_reg <= id_aw;
                            base_ok_reg <= 1'b1;
                            frame_reg   <= '0;
                            accum_reg   <= '0;
                        end
                    end
                    KIND_ONESHOT:
                    begin
                        if (id_ok && !os_ok_reg)
                        begin
                            os_id_reg <= id_aw;
                            os_ok_reg <= 1'b1;
                            frame_reg <= '0;
                            accum_reg <= '0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (cmd.update)
            begin
                accum_reg <= accum_reg - prod_reg;
                if (os_ok_reg)
                begin
                    // one-shot done: hand back to the base at frame zero
                    if (nge_reg)
                    begin
                        os_ok_reg <= 1'b0;
                        frame_reg <= '0;
                    end
                    else
                    begin
                        frame_reg <= frame_reg + FRAME_BITS'(div_quo);
                    end
                end
                else if (!nge_reg)
                begin
                    frame_reg <= frame_reg + FRAME_BITS'(div_quo);
                end
                else if (once)
                begin
                    frame_reg <= FRAME_BITS'(cnt - CN_W'(1));
                end
            end

            if (cmd.take_mod)
            begin
                frame_reg <= FRAME_BITS'(div_rem);
            end
        end
    end

    // result fields, taken after the update
    always_comb
    begin
        has_any  = os_ok_reg || base_ok_reg;
        shown    = has_any ? ID_W'(cur_id) : '0;
        frame8   = FRAME_OUT_W'(frame_reg);
        sheet    = has_any ? SHEET_W'(start_idx) + SHEET_W'(frame8) : '0;
        tick_ok  = (kind_reg == KIND_TICK) && base_ok_reg;
        out_next = OUT_DATA_W'({sheet, frame8, shown, os_ok_reg, base_ok_reg, tick_ok});
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg    <= safs_kind_t'(in_kind);
            elapsed_reg <= in_elapsed;
            id_reg      <= in_id;
        end
        if (cmd.cmp)
        begin
            nge_reg <= div_quo >= ACCUM_W'(steps_left);
        end
        if (cmd.mul)
        begin
            prod_reg <= ACCUM_W'(mul_a * ACCUM_W'(ft));
        end
        if (cmd.emit)
        begin
            out_reg <= out_next;
        end
    end

    assign sts.tick_run = (kind_reg == KIND_TICK) && base_ok_reg;
    assign sts.gt       = accum_reg > ACCUM_W'(ft);
    assign sts.div_busy = div_busy;
    assign sts.need_mod = !os_ok_reg && nge_reg && !once;
    assign out_data     = out_reg;

endmodule

`default_nettype wire

>>> hdl/safs_ctrl.sv
// safs_ctrl: sequencing state machine and result valid flag
// depends on safs_pkg
`default_nettype none

module safs_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    output logic                     out_valid,
    input  wire logic                out_ready,
    input  wire safs_pkg::safs_sts_t sts,
    output safs_pkg::safs_cmd_t      cmd
);

    import safs_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_APPLY,
        ST_CHECK,
        ST_DIV_N,
        ST_CMP,
        ST_MUL,
        ST_UPD,
        ST_DIV_M,
        ST_OUT
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_IDLE:  cmd.load      = in_valid;
            ST_APPLY: cmd.apply     = 1'b1;
            ST_CHECK: cmd.div_start = sts.gt;
            ST_DIV_N:
            begin
            end
            ST_CMP:   cmd.cmp       = 1'b1;
            ST_MUL:   cmd.mul       = 1'b1;
            ST_UPD:
            begin
                cmd.update    = 1'b1;
                cmd.div_start = sts.need_mod;
                cmd.div_mod   = 1'b1;
            end
            ST_DIV_M: cmd.take_mod  = !sts.div_busy;
            ST_OUT:   cmd.emit      = !out_valid_reg || out_ready;
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= ST_APPLY;
                    end
                end
                ST_APPLY: state_reg <= sts.tick_run ? ST_CHECK : ST_OUT;
                ST_CHECK: state_reg <= sts.gt ? ST_DIV_N : ST_OUT;
                ST_DIV_N:
                begin
                    if (!sts.div_busy)
                    begin
                        state_reg <= ST_CMP;
                    end
                end
                ST_CMP:   state_reg <= ST_MUL;
                ST_MUL:   state_reg <= ST_UPD;
                ST_UPD:   state_reg <= sts.need_mod ? ST_DIV_M : ST_OUT;
                ST_DIV_M:
                begin
                    if (!sts.div_busy)
                    begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (cmd.emit)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:  state_reg <= ST_IDLE;
            endcase
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

>>> hdl/sprite_animation_frame_sequencer.sv
// sprite_animation_frame_sequencer: top level, joins controller and datapath
// depends on safs_pkg, safs_ctrl, safs_dp (and safs_div below it)
//
// One item in, one result item out. Each input item is a tick carrying elapsed
// milliseconds, a base animation select or a one-shot start; the result reports
// the animation on show, its frame and its sheet index after that item. The
// block works on one item at a time. A select, a one-shot start, an unknown kind
// or a tick with no base goes from accept through the apply step straight to the
// result; a tick that does not pass a frame boundary adds a check step. A tick
// that does runs the shared radix-4 divider for the 32-bit frames-passed
// quotient, then compare, multiply and write-back steps; when a looping base
// runs past its last frame the divider runs a second time for the wrap
// position. The result sits in an output register, so the next item is taken
// while an earlier result still waits. The user must write the animation table
// through the cfg port only while the block is idle; the block itself does not
// enforce it. Writes to indexes beyond the table are dropped.
`default_nettype none

module sprite_animation_frame_sequencer #(
    parameter int ANIM_COUNT = safs_pkg::ANIM_COUNT_DEF,
    parameter int FRAME_BITS = safs_pkg::FRAME_BITS_DEF,
    parameter int TIME_BITS  = safs_pkg::TIME_BITS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // animation table write port
    input  wire logic                             cfg_wen,
    input  wire logic [safs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [safs_pkg::ENTRY_W-1:0]     cfg_data,
    // input items
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // elapsed_ms [15:0], anim_id [18:16], zero fill above
    input  wire logic [safs_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // kind [1:0]
    input  wire logic [safs_pkg::KIND_W-1:0]      s_axis_tuser,
    // result items
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // tick_ok [0], has_base [1], oneshot_playing [2], shown_anim [5:3],
    // frame_number [13:6], sheet_index [22:14], zero fill above
    output logic [safs_pkg::OUT_DATA_W-1:0]       m_axis_tdata
);

    import safs_pkg::*;

    safs_cmd_t cmd;
    safs_sts_t sts;

    // controller: sequences accept, update, divider passes and result hand-off
    safs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // datapath: table, frame and time state, divider, multiplier, result register
    safs_dp #(
        .ANIM_COUNT (ANIM_COUNT),
        .FRAME_BITS (FRAME_BITS),
        .TIME_BITS  (TIME_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wen    (cfg_wen),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_kind    (s_axis_tuser),
        .in_elapsed (s_axis_tdata[ELAPSED_W-1:0]),
        .in_id      (s_axis_tdata[IN_ID_LSB +: ID_W]),
        .cmd        (cmd),
        .sts        (sts),
        .out_data   (m_axis_tdata)
    );

endmodule

`default_nettype wire

>>> hdl/safs_chk.sv
// safs_chk: port-level checks on the sequencer, attached by bind
// depends on safs_pkg and sprite_animation_frame_sequencer
`default_nettype none

module safs_chk (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           s_axis_tvalid,
    input wire logic                           s_axis_tready,
    input wire logic                           m_axis_tvalid,
    input wire logic                           m_axis_tready,
    input wire logic [safs_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    import safs_pkg::*;

    logic in_acc;

    assign in_acc = s_axis_tvalid && s_axis_tready;

    // one item in flight: no accept straight after an accept
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !s_axis_tready)
        else $error("item accepted while previous item still in work");

    // a new result never appears straight after an accept
    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> !$past(in_acc))
        else $error("result raised one cycle after accept");

    // tick_ok only with a base selected
    a_tick_base: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[OUT_TICK_LSB]) |-> m_axis_tdata[OUT_BASE_LSB])
        else $error("tick_ok without a base");

    // nothing on show reads as animation zero at sheet zero
    a_blank: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tdata[OUT_BASE_LSB] && !m_axis_tdata[OUT_OS_LSB])
        |-> (m_axis_tdata[OUT_SHEET_LSB +: SHEET_W] == '0
             && m_axis_tdata[OUT_SHOWN_LSB +: ID_W] == '0))
        else $error("blank result with non-zero animation or sheet");

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind sprite_animation_frame_sequencer safs_chk u_safs_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
